// ===== hw/rtl/tccw_pkg.sv =====
// Shared types and constants for the text console character writer.
package tccw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;
  localparam int HW_LINE  = 80;   // line pitch of the display cursor address
  localparam int ROW_W    = 6;    // working row, holds up to one past row 31

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic       CFG_FILL_ATTR = 1'b0;
  localparam logic       CFG_TAB_WIDTH = 1'b1;

  localparam logic [7:0] FILL_ATTR_RST = 8'd7;
  localparam logic [4:0] TAB_WIDTH_RST = 5'd8;

  localparam logic [1:0] REQ_PUT        = 2'd0;
  localparam logic [1:0] REQ_SET_CURSOR = 2'd1;
  localparam logic [1:0] REQ_READ       = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic [7:0]  attr_byte;
    logic        write_char;
    logic        write_attr;
    logic        update_cursor;
    logic        use_given_pos;
    logic [4:0]  pos_row;
    logic [6:0]  pos_col;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [4:0]  out_row;
    logic [6:0]  out_col;
    logic [11:0] cursor_addr;
    logic        cursor_strobe;
    logic        scrolled;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } rsp_t;

  typedef struct packed {
    logic       index;
    logic [7:0] data;
  } cfg_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_NORM1, S_HANDLE, S_RMW, S_TAB, S_NORM2,
    S_SCR_RD, S_SCR_WR, S_SCR_FILL, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    MEM_NONE, MEM_RD_CELL, MEM_RD_IDX, MEM_RD_SCR,
    MEM_WR_MERGE, MEM_WR_COPY, MEM_WR_FILL, MEM_WR_ZERO
  } mem_op_t;

  typedef struct packed {
    logic    in_en;
    logic    norm;
    mem_op_t mem_op;
    logic    col_zero;
    logic    row_inc;
    logic    col_inc;
    logic    tab_init;
    logic    tab_adv;
    logic    tab_commit;
    logic    ptr_clr;
    logic    ptr_inc;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    logic       in_fire;
    logic [1:0] req_type;
    logic       is_cr;
    logic       is_lf;
    logic       is_tab;
    logic       would_scroll;
    logic       tab_done;
    logic       ptr_last_copy;
    logic       ptr_last;
    logic       idx_ok;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/tccw_if.sv =====
// Request, response and configuration channel interfaces.
interface tccw_req_if;
  import tccw_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tccw_rsp_if;
  import tccw_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tccw_cfg_if;
  import tccw_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tccw_ctrl.sv =====
// Sequencer for request handling, scrolling and the post-reset clear pass.
module tccw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  tccw_pkg::dp_stat_t stat,
  output tccw_pkg::dp_cmd_t  cmd
);
  import tccw_pkg::*;

  state_t state, state_next;
  logic   ret_fin;   // scroll returns to finish (1) or to byte handling (0)

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      ret_fin <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_NORM1) ret_fin <= 1'b0;
      if (state == S_NORM2) ret_fin <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (stat.ptr_last) state_next = S_IDLE;
      S_IDLE:     if (stat.in_fire) state_next = S_DISPATCH;
      S_DISPATCH: state_next = (stat.req_type == REQ_PUT) ? S_NORM1 : S_FIN;
      S_NORM1:    state_next = stat.would_scroll ? S_SCR_RD : S_HANDLE;
      S_HANDLE: begin
        if (stat.is_cr || stat.is_lf) state_next = S_NORM2;
        else if (stat.is_tab)         state_next = S_TAB;
        else                          state_next = S_RMW;
      end
      S_RMW:      state_next = S_NORM2;
      S_TAB:      if (stat.tab_done) state_next = S_NORM2;
      S_NORM2:    state_next = stat.would_scroll ? S_SCR_RD : S_FIN;
      S_SCR_RD:   state_next = S_SCR_WR;
      S_SCR_WR:   state_next = stat.ptr_last_copy ? S_SCR_FILL : S_SCR_RD;
      S_SCR_FILL: if (stat.ptr_last) state_next = ret_fin ? S_FIN : S_HANDLE;
      S_FIN:      if (stat.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mem_op = MEM_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.mem_op  = MEM_WR_ZERO;
        cmd.ptr_inc = 1'b1;
      end
      S_IDLE:     cmd.in_en = 1'b1;
      S_DISPATCH: if (stat.req_type == REQ_READ && stat.idx_ok) cmd.mem_op = MEM_RD_IDX;
      S_NORM1, S_NORM2: begin
        cmd.norm    = 1'b1;
        cmd.ptr_clr = stat.would_scroll;
      end
      S_HANDLE: begin
        if (stat.is_cr)       cmd.col_zero = 1'b1;
        else if (stat.is_lf)  cmd.row_inc  = 1'b1;
        else if (stat.is_tab) cmd.tab_init = 1'b1;
        else                  cmd.mem_op   = MEM_RD_CELL;
      end
      S_RMW: begin
        cmd.mem_op  = MEM_WR_MERGE;
        cmd.col_inc = 1'b1;
      end
      S_TAB: begin
        cmd.tab_adv    = !stat.tab_done;
        cmd.tab_commit = stat.tab_done;
      end
      S_SCR_RD:   cmd.mem_op = MEM_RD_SCR;
      S_SCR_WR: begin
        cmd.mem_op  = MEM_WR_COPY;
        cmd.ptr_inc = 1'b1;
      end
      S_SCR_FILL: begin
        cmd.mem_op  = MEM_WR_FILL;
        cmd.ptr_inc = 1'b1;
      end
      S_FIN:      cmd.finish = stat.out_free;
      default:    cmd.mem_op = MEM_NONE;
    endcase
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    stat.in_fire |-> state == S_IDLE)
    else $error("request accepted outside idle");
  a_fin_once: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == S_IDLE)
    else $error("finish did not return to idle");
  a_scroll_src: assert property (@(posedge clk) disable iff (rst)
    state == S_SCR_RD |-> $past(state) == S_NORM1 || $past(state) == S_NORM2 ||
                          $past(state) == S_SCR_WR)
    else $error("scroll entered from wrong state");

endmodule

// ===== hw/rtl/tccw_dp.sv =====
// Datapath: cell store, cursor, working position, tab stepper and result register.
module tccw_dp #(
  parameter int COLS = tccw_pkg::COLS_DEF,
  parameter int ROWS = tccw_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  tccw_req_if.sink          req,
  tccw_rsp_if.source        rsp,
  tccw_cfg_if.sink          cfg,
  input  tccw_pkg::dp_cmd_t cmd,
  output tccw_pkg::dp_stat_t stat
);
  import tccw_pkg::*;

  localparam int NCELLS = ROWS * COLS;
  localparam int AW     = $clog2(NCELLS);
  localparam int CW     = ($clog2(COLS + 16) > 7) ? $clog2(COLS + 16) : 7;

  logic [15:0]      mem [NCELLS];
  logic [15:0]      rdata;
  logic [7:0]       fill_attr;
  logic [4:0]       tab_width;
  req_t             rq;
  logic [4:0]       cursor_row;
  logic [6:0]       cursor_col;
  logic [ROW_W-1:0] row;
  logic [CW-1:0]    col;
  logic [CW-1:0]    acc;
  logic [AW-1:0]    ptr;
  logic             scr;
  logic             idx_ok;
  logic             out_valid;
  rsp_t             out_data;
  rsp_t             out_data_next;

  logic             in_fire;
  logic             col_wrap, would_scroll;
  logic [ROW_W-1:0] row_n1;
  logic [4:0]       tw;
  logic [AW-1:0]    cell_addr, waddr, raddr;
  logic [15:0]      wdata, merged;
  logic             we, re;
  logic [11:0]      put_addr;
  logic             out_free;

  assign cfg.ready = 1'b1;
  assign req.ready = cmd.in_en;
  assign in_fire   = req.valid && cmd.in_en;
  assign out_free  = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign tw           = (tab_width == 5'd0) ? 5'd1 : tab_width;
  assign col_wrap     = 32'(col) >= COLS;
  assign row_n1       = col_wrap ? row + ROW_W'(1) : row;
  assign would_scroll = 32'(row_n1) >= ROWS;
  assign cell_addr    = AW'(row) * AW'(COLS) + AW'(col);

  always_comb begin
    merged = rdata;
    if (rq.write_char) merged[7:0]  = rq.char_code;
    if (rq.write_attr) merged[15:8] = rq.attr_byte;
  end

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = ptr;
    raddr = ptr;
    wdata = '0;
    case (cmd.mem_op)
      MEM_RD_CELL:  begin re = 1'b1; raddr = cell_addr; end
      MEM_RD_IDX:   begin re = 1'b1; raddr = AW'(rq.cell_index); end
      MEM_RD_SCR:   begin re = 1'b1; raddr = ptr + AW'(COLS); end
      MEM_WR_MERGE: begin we = 1'b1; waddr = cell_addr; wdata = merged; end
      MEM_WR_COPY:  begin we = 1'b1; wdata = rdata; end
      MEM_WR_FILL:  begin we = 1'b1; wdata = {fill_attr, CH_SPACE}; end
      MEM_WR_ZERO:  we = 1'b1;
      default:      we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_attr <= FILL_ATTR_RST;
      tab_width <= TAB_WIDTH_RST;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        CFG_FILL_ATTR: fill_attr <= cfg.data.data;
        CFG_TAB_WIDTH: tab_width <= cfg.data.data[4:0];
        default:       fill_attr <= fill_attr;
      endcase
    end
  end

  // pointer for clear pass and scroll sweeps
  always_ff @(posedge clk) begin
    if (rst) ptr <= '0;
    else if (cmd.ptr_clr) ptr <= '0;
    else if (cmd.ptr_inc) ptr <= (32'(ptr) == NCELLS - 1) ? '0 : ptr + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row <= 5'(ROWS - 1);
      cursor_col <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (rq.req_type == REQ_PUT && !rq.use_given_pos) begin
          cursor_row <= row[4:0];
          cursor_col <= col[6:0];
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rq     <= req.data;
      idx_ok <= 32'(req.data.cell_index) < NCELLS;
      scr    <= 1'b0;
      row    <= req.data.use_given_pos ? ROW_W'(req.data.pos_row) : ROW_W'(cursor_row);
      col    <= req.data.use_given_pos ? CW'(req.data.pos_col) : CW'(cursor_col);
    end
    if (cmd.norm) begin
      if (col_wrap) col <= '0;
      row <= would_scroll ? ROW_W'(ROWS - 1) : row_n1;
      if (would_scroll) scr <= 1'b1;
    end
    if (cmd.col_zero) col <= '0;
    if (cmd.row_inc)  row <= row + ROW_W'(1);
    if (cmd.col_inc)  col <= col + CW'(1);
    if (cmd.tab_init) acc <= CW'(tw);
    if (cmd.tab_adv)  acc <= acc + CW'(tw);
    if (cmd.tab_commit) col <= acc;
  end

  // the display address always follows the own cursor after a put
  always_comb begin
    if (rq.use_given_pos)
      put_addr = 12'(cursor_row) * 12'(HW_LINE) + 12'(cursor_col);
    else
      put_addr = 12'(row) * 12'(HW_LINE) + 12'(col);
  end

  always_comb begin
    out_data_next         = '0;
    out_data_next.out_row = cursor_row;
    out_data_next.out_col = cursor_col;
    case (rq.req_type)
      REQ_PUT: begin
        out_data_next.out_row  = row[4:0];
        out_data_next.out_col  = col[6:0];
        out_data_next.scrolled = scr;
        if (rq.update_cursor) begin
          out_data_next.cursor_addr   = put_addr;
          out_data_next.cursor_strobe = 1'b1;
        end
      end
      REQ_SET_CURSOR: begin
        out_data_next.cursor_addr   = 12'(rq.pos_row) * 12'(HW_LINE) + 12'(rq.pos_col);
        out_data_next.cursor_strobe = 1'b1;
      end
      REQ_READ: begin
        if (idx_ok) begin
          out_data_next.cell_char = rdata[7:0];
          out_data_next.cell_attr = rdata[15:8];
        end
      end
      default: out_data_next.scrolled = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_data <= out_data_next;
  end

  always_comb begin
    stat               = '0;
    stat.in_fire       = in_fire;
    stat.req_type      = rq.req_type;
    stat.is_cr         = rq.char_code == CH_CR;
    stat.is_lf         = rq.char_code == CH_LF;
    stat.is_tab        = rq.char_code == CH_TAB;
    stat.would_scroll  = would_scroll;
    stat.tab_done      = acc > col;
    stat.ptr_last_copy = 32'(ptr) == NCELLS - COLS - 1;
    stat.ptr_last      = 32'(ptr) == NCELLS - 1;
    stat.idx_ok        = idx_ok;
    stat.out_free      = out_free;
  end

  a_cur_row: assert property (@(posedge clk) disable iff (rst)
    32'(cursor_row) < ROWS && 32'(cursor_col) < COLS)
    else $error("cursor outside the screen");
  a_no_strobe_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.cursor_strobe |-> out_data.cursor_addr == 12'd0)
    else $error("cursor address without strobe");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

// ===== hw/rtl/text_console_char_writer.sv =====
// Text console character writer: cursor handling, cell writes, scrolling, reads.
// After reset the cell store is cleared in a pass over all ROWS*COLS cells,
// during which no request is taken; configuration writes are always taken. One
// request is worked at a time on a single-port cell store with registered read
// data. An ordinary character is a read-modify-write of one cell; a tab steps
// the column one tab stop at a time until it passes the start column. Each
// scroll copies every row but the top one up by one row and fills the bottom
// row, and a put can scroll twice. The result register frees the output side,
// but a new request is taken only once the previous result has been loaded,
// the cycle after the load at the earliest.
module text_console_char_writer #(
  parameter int COLS = tccw_pkg::COLS_DEF,
  parameter int ROWS = tccw_pkg::ROWS_DEF
) (
  input logic        clk,
  input logic        rst,
  tccw_req_if.sink   req,
  tccw_rsp_if.source rsp,
  tccw_cfg_if.sink   cfg
);
  import tccw_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tccw_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  tccw_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cfg  (cfg),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule
